// ===== rtl/http_request_tokenizer_assert.svh =====
// Assertion macros for the HTTP request tokenizer.
`ifndef HTTP_REQUEST_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_TOKENIZER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define HTOK_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htok assertion failed");
// Next-cycle implication, disabled during reset.
`define HTOK_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htok assertion failed");
`else
`define HTOK_ASSERT_IMP(label, clk, rst, ante, cons)
`define HTOK_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/htok_pkg.sv =====
// Types and constants shared by the HTTP request tokenizer modules.
package htok_pkg;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [3:0] KIND_METHOD      = 4'd0;
   localparam logic [3:0] KIND_URL         = 4'd1;
   localparam logic [3:0] KIND_VERSION     = 4'd2;
   localparam logic [3:0] KIND_NAME        = 4'd3;
   localparam logic [3:0] KIND_VALUE       = 4'd4;
   localparam logic [3:0] KIND_REQ_LINE    = 4'd5;
   localparam logic [3:0] KIND_HEADER_LINE = 4'd6;
   localparam logic [3:0] KIND_DONE        = 4'd7;
   localparam logic [3:0] KIND_MALFORMED   = 4'd8;

   localparam logic [1:0] HELD_NONE  = 2'd0;
   localparam logic [1:0] HELD_CR    = 2'd1;
   localparam logic [1:0] HELD_COLON = 2'd2;

   localparam logic [1:0] FIELD_VERSION = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] kind;
      logic       header_ok;
      logic       last;
   } result_type;

   // Results produced by one byte, handed from the core to the queue.
   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ===== rtl/http_request_tokenizer.sv =====
// HTTP/1.1 request head tokenizer. Takes one raw byte per item and tags every
// content byte as method, URL, version, header name or header value, and adds
// marker items for request line end, header line end (with header_ok), end of
// head and malformed request line. A byte yields zero, one or two result items;
// rsp_last marks the final one of each byte. The input register accepts one
// byte per cycle while req_stall is low; the first result of a byte passes
// through the input register and the queue before it is offered. Results leave
// through a four-entry queue at one item per cycle while rsp_stall is low, and
// the input stalls while a byte waits in the input register and the queue holds
// more than two items.
`include "http_request_tokenizer_assert.svh"

module http_request_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_kind,
   output logic       rsp_header_ok,
   output logic       rsp_last
);
   import htok_pkg::*;

   push_type   push;
   result_type item;
   logic       in_ready;
   logic       room;

   htok_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_byte  (req_in_byte),
      .in_ready (in_ready),
      .room     (room),
      .push     (push)
   );

   htok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (item)
   );

   assign req_stall     = !in_ready;
   assign rsp_out_byte  = item.out_byte;
   assign rsp_kind      = item.kind;
   assign rsp_header_ok = item.header_ok;
   assign rsp_last      = item.last;

   `HTOK_ASSERT_IMP(a_last_single, clock, reset, push.valid && push.count == 2'd1, push.r0.last)
   `HTOK_ASSERT_IMP(a_last_pair, clock, reset, push.valid && push.count == 2'd2, !push.r0.last && push.r1.last)
   `HTOK_ASSERT_IMP(a_marker_clean, clock, reset, rsp_valid && rsp_kind >= KIND_REQ_LINE, rsp_out_byte == 8'd0)
   `HTOK_ASSERT_IMP(a_ok_only_hdr, clock, reset, rsp_valid && rsp_kind != KIND_HEADER_LINE, !rsp_header_ok)
   `HTOK_ASSERT_NXT(a_queue_empty, clock, reset, $rose(push.valid) && push.count == 2'd0 && !rsp_valid, !rsp_valid)

endmodule

// ===== rtl/htok_core.sv =====
// Input register, tokenizer state and per-byte decode logic.
module htok_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   output logic              in_ready,
   input  logic              room,
   output htok_pkg::push_type push
);
   import htok_pkg::*;

   typedef struct packed {
      logic       phase;
      logic [1:0] field_index;
      logic [1:0] held_kind;
      logic       after_sep;
      logic       name_ne;
      logic       value_ne;
      logic       line_ne;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      logic [1:0]    count;
      result_type    r0;
      result_type    r1;
   } step_type;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   tok_state_type state_ff, state_in;
   step_type      step;
   logic          fire;

   function automatic step_type emit(step_type s, logic [7:0] b, logic [3:0] k, logic ok);
      result_type r;
      r.out_byte  = b;
      r.kind      = k;
      r.header_ok = ok;
      r.last      = 1'b0;
      if (s.count == 2'd0) begin
         s.r0    = r;
         s.count = 2'd1;
      end else if (s.count == 2'd1) begin
         s.r1    = r;
         s.count = 2'd2;
      end
      return s;
   endfunction

   function automatic step_type emit_content(step_type s, logic [7:0] b);
      s.st.line_ne = 1'b1;
      if (!s.st.phase) begin
         s = emit(s, b, (s.st.field_index > FIELD_VERSION) ? KIND_VERSION
                                                          : {2'b00, s.st.field_index}, 1'b0);
      end else if (s.st.after_sep) begin
         s.st.value_ne = 1'b1;
         s = emit(s, b, KIND_VALUE, 1'b0);
      end else begin
         s.st.name_ne = 1'b1;
         s = emit(s, b, KIND_NAME, 1'b0);
      end
      return s;
   endfunction

   function automatic step_type clear_line(step_type s);
      s.st.field_index = 2'd0;
      s.st.after_sep   = 1'b0;
      s.st.name_ne     = 1'b0;
      s.st.value_ne    = 1'b0;
      s.st.line_ne     = 1'b0;
      return s;
   endfunction

   function automatic step_type line_end(step_type s);
      if (!s.st.phase) begin
         if (s.st.line_ne) begin
            if (s.st.field_index < FIELD_VERSION) begin
               s = emit(s, 8'd0, KIND_MALFORMED, 1'b0);
            end else begin
               s = emit(s, 8'd0, KIND_REQ_LINE, 1'b0);
               s.st.phase = 1'b1;
            end
            s = clear_line(s);
         end
      end else begin
         if (!s.st.line_ne) begin
            s = emit(s, 8'd0, KIND_DONE, 1'b0);
            s.st.phase = 1'b0;
         end else begin
            s = emit(s, 8'd0, KIND_HEADER_LINE,
                     s.st.after_sep & s.st.name_ne & s.st.value_ne);
         end
         s = clear_line(s);
      end
      return s;
   endfunction

   function automatic step_type plain_byte(step_type s, logic [7:0] b);
      priority if (b == CH_CR) begin
         s.st.held_kind = HELD_CR;
      end else if (!s.st.phase && b == CH_SP && s.st.field_index < FIELD_VERSION) begin
         s.st.field_index = 2'(s.st.field_index + 2'd1);
         s.st.line_ne     = 1'b1;
      end else if (s.st.phase && b == CH_COLON && !s.st.after_sep) begin
         s.st.held_kind = HELD_COLON;
         s.st.line_ne   = 1'b1;
      end else begin
         s = emit_content(s, b);
      end
      return s;
   endfunction

   always_comb begin
      step           = '0;
      step.st        = state_ff;
      step.st.held_kind = HELD_NONE;
      unique case (state_ff.held_kind)
         HELD_CR: begin
            if (in_byte_ff == CH_LF) begin
               step = line_end(step);
            end else begin
               step = emit_content(step, CH_CR);
               step = plain_byte(step, in_byte_ff);
            end
         end
         HELD_COLON: begin
            if (in_byte_ff == CH_SP && state_ff.phase && !state_ff.after_sep) begin
               step.st.after_sep = 1'b1;
               step.st.line_ne   = 1'b1;
            end else begin
               step = emit_content(step, CH_COLON);
               step = plain_byte(step, in_byte_ff);
            end
         end
         default: begin
            step = plain_byte(step, in_byte_ff);
         end
      endcase
      if (step.count == 2'd1) begin
         step.r0.last = 1'b1;
      end
      if (step.count == 2'd2) begin
         step.r1.last = 1'b1;
      end
   end

   assign fire     = in_valid_ff && room;
   assign in_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      state_in    = state_ff;
      if (fire) begin
         in_valid_in = 1'b0;
         state_in    = step.st;
      end
      if (in_valid && in_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_byte_ff <= in_byte_in;
   end

   assign push.valid = fire;
   assign push.count = step.count;
   assign push.r0    = step.r0;
   assign push.r1    = step.r1;

endmodule

// ===== rtl/htok_queue.sv =====
// Four-entry result queue: takes up to two items per cycle, delivers one when out_stall is low.
module htok_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  htok_pkg::push_type   push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_stall,
   output htok_pkg::result_type out_item
);
   import htok_pkg::*;

   result_type entries_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_n;
   logic       pop;

   assign out_valid = count_ff != 3'd0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign room      = count_ff <= 3'd2;
   assign pop       = out_valid && !out_stall;
   assign push_n    = push.valid ? push.count : 2'd0;

   always_comb begin
      wr_ptr_in = 2'(wr_ptr_ff + push_n);
      rd_ptr_in = pop ? 2'(rd_ptr_ff + 2'd1) : rd_ptr_ff;
      count_in  = 3'(count_ff + {1'b0, push_n} - {2'b00, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push_n == 2'd2) begin
         entries_ff[2'(wr_ptr_ff + 2'd1)] <= push.r1;
      end
   end

endmodule
